FILE: hw/rtl/mmlp_pkg.sv
// Shared types, codes and helpers for the memory-map line parser.
package mmlp_pkg;

  // Default size of the per-line name capture and the register reset value.
  localparam int unsigned NAME_CAP_DEFAULT  = 256;
  localparam logic [15:0] MAX_ENTRIES_RESET = 16'd1024;

  // Depth of the queue between front and back, and of the result queue.
  localparam int unsigned QUEUE_DEPTH = 2;

  // Characters that steer the parse.
  localparam logic [7:0] CHAR_NEWLINE = 8'h0a;
  localparam logic [7:0] CHAR_DASH    = 8'h2d;
  localparam logic [7:0] CHAR_SPACE   = 8'h20;

  // Number of columns skipped before the name starts.
  localparam logic [2:0] SKIP_COLUMNS = 3'd4;

  // Hex fields longer than this many digits are rejected.
  localparam logic [4:0] HEX_DIGITS_MAX = 5'd16;
  localparam logic [4:0] HEX_DIGITS_SAT = 5'd17;

  // Result kinds.
  localparam logic [1:0] KIND_NAME  = 2'd0;
  localparam logic [1:0] KIND_ENTRY = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;

  // Error codes.
  localparam logic [1:0] ERR_SYNTAX     = 2'd0;
  localparam logic [1:0] ERR_HEX_FIELD  = 2'd1;
  localparam logic [1:0] ERR_NO_NEWLINE = 2'd2;

  // One classified input byte, passed from front to back.
  typedef struct packed {
    logic [7:0] data;
    logic       eob;
    logic       is_hex;
    logic [3:0] hex_val;
    logic       is_newline;
    logic       is_dash;
    logic       is_blank;
  } mmlp_class_t;

  // One result item.
  typedef struct packed {
    logic [1:0]  kind;
    logic [63:0] range_base;
    logic [63:0] range_limit;
    logic [7:0]  name_byte;
    logic [7:0]  name_length;
    logic [15:0] entry_index;
    logic [1:0]  error_code;
  } mmlp_result_t;

  // Hex digit decode: bit 4 marks a valid digit, bits 3:0 hold its value.
  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [4:0] r;
    case (c) inside
      [8'h30:8'h39]: r = {1'b1, 4'(c - 8'h30)};
      [8'h61:8'h66]: r = {1'b1, 4'(c - 8'h57)};
      [8'h41:8'h46]: r = {1'b1, 4'(c - 8'h37)};
      default:       r = 5'd0;
    endcase
    return r;
  endfunction

endpackage

FILE: hw/rtl/mmlp_fifo.sv
// Small register-based first-in first-out queue with show-ahead read.
module mmlp_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full     = (count == CNT_W'(DEPTH));
  assign empty    = (count == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem[rd_ptr];

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Storage needs no reset.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

endmodule

FILE: hw/rtl/mmlp_front.sv
// Front end: accepts input bytes and tags each one with its character class.
module mmlp_front (
  input  logic                 push,
  input  logic [7:0]           data_byte,
  input  logic                 end_of_buffer,
  output logic                 full,
  input  logic                 cmd_full,
  output logic                 cmd_push,
  output mmlp_pkg::mmlp_class_t cmd_item
);

  logic [4:0] hex;

  assign hex      = mmlp_pkg::hex_decode(data_byte);
  assign full     = cmd_full;
  assign cmd_push = push && !cmd_full;

  // Classify the byte once so the back end steers its parse on flags alone.
  always_comb begin
    cmd_item            = '0;
    cmd_item.data       = data_byte;
    cmd_item.eob        = end_of_buffer;
    cmd_item.is_hex     = hex[4];
    cmd_item.hex_val    = hex[3:0];
    cmd_item.is_newline = (data_byte == mmlp_pkg::CHAR_NEWLINE);
    cmd_item.is_dash    = (data_byte == mmlp_pkg::CHAR_DASH);
    cmd_item.is_blank   = (data_byte == mmlp_pkg::CHAR_SPACE);
  end

endmodule

FILE: hw/rtl/mmlp_back.sv
// Back end: runs the line parser over classified bytes and forms results.
module mmlp_back #(
  parameter int unsigned NAME_CAP = mmlp_pkg::NAME_CAP_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [15:0]           cfg_data,
  input  logic                  cmd_empty,
  input  mmlp_pkg::mmlp_class_t cmd_item,
  output logic                  cmd_pop,
  input  logic                  res_full,
  output logic                  res_push,
  output mmlp_pkg::mmlp_result_t res_item,
  output logic                  halted
);

  localparam int unsigned NC_W = $clog2(NAME_CAP);

  typedef enum logic [2:0] {
    PH_HEX1,
    PH_HEX2,
    PH_FIND_SPACE,
    PH_FIND_NONSPACE,
    PH_NAME
  } phase_t;

  phase_t      phase, phase_next;
  logic [63:0] start_accum, start_accum_next;
  logic [63:0] limit_accum, limit_accum_next;
  logic [4:0]  digit_count, digit_count_next;
  logic [2:0]  column_count, column_count_next;
  logic [NC_W-1:0] name_count, name_count_next;
  logic [15:0] entries_done, entries_done_next;
  logic        start_bad, start_bad_next;
  logic        halted_next;
  logic [15:0] max_entries;

  logic        step;
  logic        gated;
  logic [4:0]  digit_sat;
  logic [2:0]  column_inc;
  logic        name_room;

  assign step      = !cmd_empty && !res_full;
  assign cmd_pop   = step;
  assign gated     = (phase == PH_HEX1) && (digit_count == '0) &&
                     (entries_done >= max_entries);
  assign digit_sat = (digit_count < mmlp_pkg::HEX_DIGITS_SAT) ? digit_count + 1'b1
                                                               : digit_count;
  assign column_inc = column_count + 1'b1;
  assign name_room  = (name_count != NC_W'(NAME_CAP - 1));

  // Parser step for one byte.
  always_comb begin
    phase_next        = phase;
    start_accum_next  = start_accum;
    limit_accum_next  = limit_accum;
    digit_count_next  = digit_count;
    column_count_next = column_count;
    name_count_next   = name_count;
    entries_done_next = entries_done;
    start_bad_next    = start_bad;
    halted_next       = halted;
    res_push          = 1'b0;
    res_item          = '0;
    res_item.entry_index = entries_done;
    res_item.range_base  = start_accum;
    res_item.range_limit = limit_accum;
    res_item.name_length = 8'(name_count);

    if (step && !halted && !gated) begin
      if (cmd_item.eob && !cmd_item.is_newline) begin
        // A last byte that is not a newline ends the listing badly.
        halted_next     = 1'b1;
        res_push        = 1'b1;
        res_item        = '0;
        res_item.kind        = mmlp_pkg::KIND_ERROR;
        res_item.entry_index = entries_done;
        res_item.error_code  = mmlp_pkg::ERR_NO_NEWLINE;
      end else begin
        case (phase)
          PH_HEX1: begin
            if (cmd_item.is_hex) begin
              if (digit_count < mmlp_pkg::HEX_DIGITS_MAX) begin
                start_accum_next = {start_accum[59:0], cmd_item.hex_val};
              end
              digit_count_next = digit_sat;
            end else if (cmd_item.is_dash) begin
              start_bad_next   = (digit_count == '0) ||
                                 (digit_count > mmlp_pkg::HEX_DIGITS_MAX);
              digit_count_next = '0;
              phase_next       = PH_HEX2;
            end else begin
              halted_next = 1'b1;
              res_push    = 1'b1;
              res_item    = '0;
              res_item.kind        = mmlp_pkg::KIND_ERROR;
              res_item.entry_index = entries_done;
              res_item.error_code  = mmlp_pkg::ERR_SYNTAX;
            end
          end
          PH_HEX2: begin
            if (cmd_item.is_hex) begin
              if (digit_count < mmlp_pkg::HEX_DIGITS_MAX) begin
                limit_accum_next = {limit_accum[59:0], cmd_item.hex_val};
              end
              digit_count_next = digit_sat;
            end else if (cmd_item.is_newline) begin
              halted_next = 1'b1;
              res_push    = 1'b1;
              res_item    = '0;
              res_item.kind        = mmlp_pkg::KIND_ERROR;
              res_item.entry_index = entries_done;
              res_item.error_code  = mmlp_pkg::ERR_SYNTAX;
            end else if (start_bad || (digit_count == '0) ||
                         (digit_count > mmlp_pkg::HEX_DIGITS_MAX)) begin
              halted_next = 1'b1;
              res_push    = 1'b1;
              res_item    = '0;
              res_item.kind        = mmlp_pkg::KIND_ERROR;
              res_item.entry_index = entries_done;
              res_item.error_code  = mmlp_pkg::ERR_HEX_FIELD;
            end else begin
              // The byte that ends the limit field is the first skipped byte.
              digit_count_next  = '0;
              column_count_next = '0;
              phase_next        = PH_FIND_SPACE;
            end
          end
          PH_FIND_SPACE, PH_FIND_NONSPACE, PH_NAME: begin
            if (cmd_item.is_newline) begin
              // End of line: report the entry and start the next line.
              res_push          = 1'b1;
              res_item.kind     = mmlp_pkg::KIND_ENTRY;
              entries_done_next = entries_done + 1'b1;
              phase_next        = PH_HEX1;
              start_accum_next  = '0;
              limit_accum_next  = '0;
              digit_count_next  = '0;
              column_count_next = '0;
              name_count_next   = '0;
              start_bad_next    = 1'b0;
            end else if (phase == PH_FIND_SPACE) begin
              if (cmd_item.is_blank) begin
                phase_next = PH_FIND_NONSPACE;
              end
            end else if ((phase == PH_FIND_NONSPACE) && cmd_item.is_blank) begin
              // Still inside the run of spaces.
            end else begin
              if (phase == PH_FIND_NONSPACE) begin
                column_count_next = column_inc;
              end
              if ((phase == PH_FIND_NONSPACE) && (column_inc < mmlp_pkg::SKIP_COLUMNS)) begin
                phase_next = PH_FIND_SPACE;
              end else begin
                // Name byte, emitted while there is room for it.
                phase_next = PH_NAME;
                if (name_room) begin
                  name_count_next      = name_count + 1'b1;
                  res_push             = 1'b1;
                  res_item.kind        = mmlp_pkg::KIND_NAME;
                  res_item.name_byte   = cmd_item.data;
                  res_item.name_length = 8'(name_count_next);
                end
              end
            end
          end
          default: begin
            phase_next = PH_HEX1;
          end
        endcase
      end
    end
  end

  // Parser state and the configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_HEX1;
      start_accum  <= '0;
      limit_accum  <= '0;
      digit_count  <= '0;
      column_count <= '0;
      name_count   <= '0;
      entries_done <= '0;
      start_bad    <= 1'b0;
      halted       <= 1'b0;
      max_entries  <= mmlp_pkg::MAX_ENTRIES_RESET;
    end else begin
      phase        <= phase_next;
      start_accum  <= start_accum_next;
      limit_accum  <= limit_accum_next;
      digit_count  <= digit_count_next;
      column_count <= column_count_next;
      name_count   <= name_count_next;
      entries_done <= entries_done_next;
      start_bad    <= start_bad_next;
      halted       <= halted_next;
      if (cfg_write) begin
        max_entries <= cfg_data;
      end
    end
  end

endmodule

FILE: hw/rtl/memory_map_line_parser.sv
// Parses a process memory-map listing fed one byte per item and returns, per
// line, the name bytes as they arrive followed by an entry item carrying the
// start and limit addresses. It takes one byte every clock cycle while the reader
// keeps up. Each byte waits in a two-deep byte queue; the parse step in the back
// end takes it from there and writes the result it causes into a two-deep result
// queue, so a stalled reader stops input only once both queues are full. A
// syntax fault, a bad hex field or a last byte that is not a newline gives one
// error item and halts the block until reset. Write max_entries only while idle.
module memory_map_line_parser #(
  parameter int unsigned NAME_CAP = mmlp_pkg::NAME_CAP_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  data_byte,
  input  logic        end_of_buffer,
  input  logic        cfg_write,
  input  logic [15:0] cfg_data,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  result_kind,
  output logic [63:0] range_base,
  output logic [63:0] range_limit,
  output logic [7:0]  name_byte,
  output logic [7:0]  name_length,
  output logic [15:0] entry_index,
  output logic [1:0]  error_code
);

  mmlp_pkg::mmlp_class_t  cmd_in, cmd_out;
  mmlp_pkg::mmlp_result_t res_in, res_out;
  logic cmd_push, cmd_full, cmd_pop, cmd_empty;
  logic res_push, res_full;
  logic halted;

  // Front end: byte classification.
  mmlp_front u_front (
    .push          (push),
    .data_byte     (data_byte),
    .end_of_buffer (end_of_buffer),
    .full          (full),
    .cmd_full      (cmd_full),
    .cmd_push      (cmd_push),
    .cmd_item      (cmd_in)
  );

  // Queue of classified bytes.
  mmlp_fifo #(
    .WIDTH ($bits(mmlp_pkg::mmlp_class_t)),
    .DEPTH (mmlp_pkg::QUEUE_DEPTH)
  ) u_cmd_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (cmd_push),
    .push_data (cmd_in),
    .full      (cmd_full),
    .pop       (cmd_pop),
    .pop_data  (cmd_out),
    .empty     (cmd_empty)
  );

  // Back end: the line parser.
  mmlp_back #(
    .NAME_CAP (NAME_CAP)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .cmd_empty (cmd_empty),
    .cmd_item  (cmd_out),
    .cmd_pop   (cmd_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res_item  (res_in),
    .halted    (halted)
  );

  // Result queue facing the reader.
  mmlp_fifo #(
    .WIDTH ($bits(mmlp_pkg::mmlp_result_t)),
    .DEPTH (mmlp_pkg::QUEUE_DEPTH)
  ) u_res_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (res_push),
    .push_data (res_in),
    .full      (res_full),
    .pop       (pop),
    .pop_data  (res_out),
    .empty     (empty)
  );

  assign result_kind = res_out.kind;
  assign range_base  = res_out.range_base;
  assign range_limit = res_out.range_limit;
  assign name_byte   = res_out.name_byte;
  assign name_length = res_out.name_length;
  assign entry_index = res_out.entry_index;
  assign error_code  = res_out.error_code;

  // Once halted, the parser stays halted until reset.
  a_halt_sticky: assert property (@(posedge clk) disable iff (rst)
    halted |=> halted)
    else $error("halt flag cleared without reset");

  // A halted parser never produces another item.
  a_halt_silent: assert property (@(posedge clk) disable iff (rst)
    halted |-> !res_push)
    else $error("item produced after halt");

  // The parser only pushes into a result queue that has room.
  a_res_room: assert property (@(posedge clk) disable iff (rst)
    res_push |-> !res_full)
    else $error("result pushed into a full queue");

  // An error item that is pushed halts the parser on the next cycle.
  a_error_halts: assert property (@(posedge clk) disable iff (rst)
    (res_push && (res_in.kind == mmlp_pkg::KIND_ERROR)) |=> halted)
    else $error("error item without halt");

endmodule

FILE: test/memory_map_line_parser_tb.sv
module memory_map_line_parser_tb;

  localparam int unsigned NAME_LIMIT = mmlp_pkg::NAME_CAP_DEFAULT;
  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE_CYCLES = 10;
  localparam logic [1:0] NO_ERROR = 2'd0;

  // Where the parser stands within the current line.
  typedef enum logic [2:0] {AT_START, AT_LIMIT, SEEK_SPACE, SEEK_WORD, IN_NAME} scan_t;

  // One row of the directed script; typed rows carry their result written out.
  typedef struct {
    logic [7:0]             b;
    logic                   eob;
    bit                     typed;
    mmlp_pkg::mmlp_result_t want;
  } row_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic        full;
  logic [7:0]  data_byte = 8'd0;
  logic        end_of_buffer = 1'b0;
  logic        cfg_write = 1'b0;
  logic [15:0] cfg_data = 16'd0;
  logic        empty;
  logic        pop = 1'b0;
  logic [1:0]  result_kind;
  logic [63:0] range_base;
  logic [63:0] range_limit;
  logic [7:0]  name_byte;
  logic [7:0]  name_length;
  logic [15:0] entry_index;
  logic [1:0]  error_code;

  // Typed expectation that travels with the item being offered.
  bit                     row_typed = 1'b0;
  mmlp_pkg::mmlp_result_t row_want = '0;

  // Parser state as predicted by the testbench.
  scan_t       step;
  logic [63:0] start_acc;
  logic [63:0] limit_acc;
  logic [4:0]  ndigits;
  logic [2:0]  cols;
  int          name_len;
  logic [15:0] lines_done;
  logic [15:0] entry_cap;
  bit          stopped;
  bit          start_faulty;

  mmlp_pkg::mmlp_result_t results_due[$];
  mmlp_pkg::mmlp_result_t due;
  mmlp_pkg::mmlp_result_t guess;
  bit           produced;
  logic [7:0]   line_text[$];
  int           mismatches = 0;
  int           cycles = 0;
  int           bytes_sent = 0;
  int           send_gap_pct = 0;
  int           pop_gap_pct = 0;

  // Directed lines: a full line whose name holds the extreme byte values, ended by a
  // newline that also marks the end of the buffer, then a short line with no name.
  row_t script [19] = '{
    '{"a",                  1'b0, 1'b0, '0},
    '{mmlp_pkg::CHAR_DASH,  1'b0, 1'b0, '0},
    '{"B",                  1'b0, 1'b0, '0},
    '{"p",                  1'b0, 1'b0, '0},
    '{mmlp_pkg::CHAR_SPACE, 1'b0, 1'b0, '0},
    '{"x",                  1'b0, 1'b0, '0},
    '{mmlp_pkg::CHAR_SPACE, 1'b0, 1'b0, '0},
    '{"x",                  1'b0, 1'b0, '0},
    '{mmlp_pkg::CHAR_SPACE, 1'b0, 1'b0, '0},
    '{"x",                  1'b0, 1'b0, '0},
    '{mmlp_pkg::CHAR_SPACE, 1'b0, 1'b0, '0},
    '{8'hff, 1'b0, 1'b1,
      {mmlp_pkg::KIND_NAME, 64'ha, 64'hb, 8'hff, 8'd1, 16'd0, NO_ERROR}},
    '{8'h00, 1'b0, 1'b1,
      {mmlp_pkg::KIND_NAME, 64'ha, 64'hb, 8'h00, 8'd2, 16'd0, NO_ERROR}},
    '{mmlp_pkg::CHAR_NEWLINE, 1'b1, 1'b1,
      {mmlp_pkg::KIND_ENTRY, 64'ha, 64'hb, 8'h00, 8'd2, 16'd0, NO_ERROR}},
    '{"0",                  1'b0, 1'b0, '0},
    '{mmlp_pkg::CHAR_DASH,  1'b0, 1'b0, '0},
    '{"0",                  1'b0, 1'b0, '0},
    '{mmlp_pkg::CHAR_SPACE, 1'b0, 1'b0, '0},
    '{mmlp_pkg::CHAR_NEWLINE, 1'b0, 1'b1,
      {mmlp_pkg::KIND_ENTRY, 64'h0, 64'h0, 8'h00, 8'd0, 16'd1, NO_ERROR}}
  };

  memory_map_line_parser #(.NAME_CAP(NAME_LIMIT)) dut (
    .clk(clk),
    .rst(rst),
    .push(push),
    .full(full),
    .data_byte(data_byte),
    .end_of_buffer(end_of_buffer),
    .cfg_write(cfg_write),
    .cfg_data(cfg_data),
    .empty(empty),
    .pop(pop),
    .result_kind(result_kind),
    .range_base(range_base),
    .range_limit(range_limit),
    .name_byte(name_byte),
    .name_length(name_length),
    .entry_index(entry_index),
    .error_code(error_code)
  );

  // Clock.
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Hex digit test; the low nibble gives the value, plus nine for letters.
  function automatic bit hex_digit(input logic [7:0] c, output logic [3:0] v);
    v = c[3:0];
    if (c >= "0" && c <= "9") return 1'b1;
    v = c[3:0] + 4'd9;
    return (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
  endfunction

  function automatic void clear_line();
    step = AT_START;
    start_acc = '0;
    limit_acc = '0;
    ndigits = '0;
    cols = '0;
    name_len = 0;
    start_faulty = 1'b0;
  endfunction

  function automatic mmlp_pkg::mmlp_result_t shape_result(logic [1:0] kind, logic [7:0] nb,
                                                          logic [1:0] code);
    mmlp_pkg::mmlp_result_t r;
    bit err;
    err = (kind == mmlp_pkg::KIND_ERROR);
    r.kind = kind;
    r.range_base = err ? '0 : start_acc;
    r.range_limit = err ? '0 : limit_acc;
    r.name_byte = nb;
    r.name_length = err ? 8'd0 : 8'(name_len);
    r.entry_index = lines_done;
    r.error_code = code;
    return r;
  endfunction

  // Digits past the sixteenth are counted but not shifted in.
  function automatic void take_digit(inout logic [63:0] acc, input logic [3:0] v);
    if (ndigits < mmlp_pkg::HEX_DIGITS_MAX) acc = {acc[59:0], v};
    if (ndigits < mmlp_pkg::HEX_DIGITS_SAT) ndigits++;
  endfunction

  function automatic bit raise_fault(input logic [1:0] code,
                                     output mmlp_pkg::mmlp_result_t r);
    stopped = 1'b1;
    r = shape_result(mmlp_pkg::KIND_ERROR, 8'd0, code);
    return 1'b1;
  endfunction

  function automatic bit close_entry(output mmlp_pkg::mmlp_result_t r);
    r = shape_result(mmlp_pkg::KIND_ENTRY, 8'd0, NO_ERROR);
    lines_done++;
    clear_line();
    return 1'b1;
  endfunction

  // Name bytes beyond one less than the capture size are dropped silently.
  function automatic bit take_name(input logic [7:0] b, output mmlp_pkg::mmlp_result_t r);
    r = '0;
    if (name_len + 1 < NAME_LIMIT) begin
      name_len++;
      r = shape_result(mmlp_pkg::KIND_NAME, b, NO_ERROR);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // Advances the predicted parser by one byte; returns 1 when a result is due.
  function automatic bit parse_byte(input logic [7:0] b, input logic eob,
                                    output mmlp_pkg::mmlp_result_t r);
    logic [3:0] v;
    bit isd;
    r = '0;
    isd = hex_digit(b, v);
    if (stopped) return 1'b0;
    if (step == AT_START && ndigits == 0 && lines_done >= entry_cap) return 1'b0;
    if (eob && b != mmlp_pkg::CHAR_NEWLINE) return raise_fault(mmlp_pkg::ERR_NO_NEWLINE, r);
    case (step)
      AT_START: begin
        if (isd) begin
          take_digit(start_acc, v);
        end else if (b == mmlp_pkg::CHAR_DASH) begin
          start_faulty = (ndigits == 0 || ndigits > mmlp_pkg::HEX_DIGITS_MAX);
          ndigits = '0;
          step = AT_LIMIT;
        end else begin
          return raise_fault(mmlp_pkg::ERR_SYNTAX, r);
        end
        return 1'b0;
      end
      AT_LIMIT: begin
        if (isd) begin
          take_digit(limit_acc, v);
          return 1'b0;
        end
        if (b == mmlp_pkg::CHAR_NEWLINE) return raise_fault(mmlp_pkg::ERR_SYNTAX, r);
        if (start_faulty || ndigits == 0 || ndigits > mmlp_pkg::HEX_DIGITS_MAX)
          return raise_fault(mmlp_pkg::ERR_HEX_FIELD, r);
        ndigits = '0;
        cols = '0;
        step = SEEK_SPACE;
        return 1'b0;
      end
      SEEK_SPACE: begin
        if (b == mmlp_pkg::CHAR_NEWLINE) return close_entry(r);
        if (b == mmlp_pkg::CHAR_SPACE) step = SEEK_WORD;
        return 1'b0;
      end
      SEEK_WORD: begin
        if (b == mmlp_pkg::CHAR_NEWLINE) return close_entry(r);
        if (b == mmlp_pkg::CHAR_SPACE) return 1'b0;
        cols++;
        if (cols >= mmlp_pkg::SKIP_COLUMNS) begin
          step = IN_NAME;
          return take_name(b, r);
        end
        step = SEEK_SPACE;
        return 1'b0;
      end
      default: begin
        if (b == mmlp_pkg::CHAR_NEWLINE) return close_entry(r);
        return take_name(b, r);
      end
    endcase
  endfunction

  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endfunction

  // Prediction on every accepted item and comparison on every accepted result.
  always @(posedge clk) begin
    if (rst) begin
      entry_cap = mmlp_pkg::MAX_ENTRIES_RESET;
      lines_done = '0;
      stopped = 1'b0;
      clear_line();
      results_due.delete();
    end else begin
      if (cfg_write) entry_cap = cfg_data;
      if (push && !full) begin
        produced = parse_byte(data_byte, end_of_buffer, guess);
        if (row_typed) results_due.push_back(row_want);
        else if (produced) results_due.push_back(guess);
      end
      if (pop && !empty) begin
        if (results_due.size() == 0) begin
          $error("result item with none expected, kind %0d", result_kind);
          mismatches++;
        end else begin
          due = results_due.pop_front();
          check_field("result_kind", due.kind, result_kind);
          check_field("range_base", due.range_base, range_base);
          check_field("range_limit", due.range_limit, range_limit);
          check_field("name_byte", due.name_byte, name_byte);
          check_field("name_length", due.name_length, name_length);
          check_field("entry_index", due.entry_index, entry_index);
          check_field("error_code", due.error_code, error_code);
        end
      end
    end
  end

  // Receiver stalls at random.
  always @(posedge clk) begin
    pop <= ($urandom_range(99) >= pop_gap_pct);
  end

  // Watchdog.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("memory_map_line_parser_tb: done, errors");
      $finish;
    end
  end

  // Offers one item, at times after a random gap, and returns once it is taken.
  task automatic send_item(input logic [7:0] b, input logic eob, input bit typed = 1'b0,
                           input mmlp_pkg::mmlp_result_t want = '0);
    if ($urandom_range(99) < send_gap_pct) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    push <= 1'b1;
    data_byte <= b;
    end_of_buffer <= eob;
    row_typed <= typed;
    row_want <= want;
    do @(posedge clk); while (full);
    bytes_sent++;
  endtask

  // Stops sending and waits until every expected result is in and the block is quiet.
  task automatic wait_idle();
    push <= 1'b0;
    @(posedge clk);
    while (results_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_cap(input logic [15:0] value);
    cfg_write <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] v);
    if (v < 10) return 8'("0" + v);
    return 8'(($urandom_range(1) ? "a" : "A") + v - 10);
  endfunction

  function automatic logic [7:0] text_byte(input bit allow_space);
    logic [7:0] c;
    do c = 8'($urandom_range(255));
    while (c == mmlp_pkg::CHAR_NEWLINE || (!allow_space && c == mmlp_pkg::CHAR_SPACE));
    return c;
  endfunction

  // Hex field: all ones, sixteen random digits, or a short random one.
  function automatic void add_hex_field();
    int mode;
    int nd;
    mode = $urandom_range(3);
    nd = (mode < 2) ? mmlp_pkg::HEX_DIGITS_MAX : $urandom_range(1, 5);
    for (int i = 0; i < nd; i++)
      line_text.push_back(hex_char(mode == 0 ? 4'hf : 4'($urandom_range(15))));
  endfunction

  // Builds one well-formed line; a negative size picks a random name length.
  function automatic void make_line(input int name_size);
    int ncols;
    logic [7:0] c;
    logic [3:0] v;
    line_text = {};
    add_hex_field();
    line_text.push_back(mmlp_pkg::CHAR_DASH);
    add_hex_field();
    if ($urandom_range(1)) c = mmlp_pkg::CHAR_SPACE;
    else do c = text_byte(1'b1); while (hex_digit(c, v));
    line_text.push_back(c);
    ncols = ($urandom_range(9) < 7 || name_size >= 0) ? mmlp_pkg::SKIP_COLUMNS
                                                      : $urandom_range(3);
    for (int k = 0; k < ncols; k++) begin
      repeat ($urandom_range(2)) line_text.push_back(text_byte(1'b0));
      repeat ($urandom_range(1, 3)) line_text.push_back(mmlp_pkg::CHAR_SPACE);
      line_text.push_back(text_byte(1'b0));
    end
    if (ncols == mmlp_pkg::SKIP_COLUMNS) begin
      if (name_size < 0) name_size = $urandom_range(1, 12);
      repeat (name_size - 1) line_text.push_back(text_byte(1'b1));
    end else begin
      repeat ($urandom_range(2)) line_text.push_back(text_byte(1'b1));
    end
    line_text.push_back(mmlp_pkg::CHAR_NEWLINE);
  endfunction

  // Newlines may or may not mark the end of the buffer.
  task automatic send_span(input int first, input int last);
    for (int i = first; i <= last; i++)
      send_item(line_text[i],
                line_text[i] == mmlp_pkg::CHAR_NEWLINE ? 1'($urandom_range(1)) : 1'b0);
  endtask

  task automatic run_lines(input int count);
    int goal;
    goal = bytes_sent + count;
    while (bytes_sent < goal) begin
      make_line(-1);
      send_span(0, line_text.size() - 1);
    end
  endtask

  task automatic send_noise(input int count);
    repeat (count) send_item(8'($urandom_range(255)), 1'($urandom_range(1)));
  endtask

  // Stimulus.
  initial begin
    int split;
    logic [1:0] fault_pick;
    send_gap_pct = 35;
    pop_gap_pct = 50;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (script[i]) send_item(script[i].b, script[i].eob, script[i].typed, script[i].want);

    // With no entries allowed, every byte is dropped, even one marking the buffer end.
    wait_idle();
    write_cap(16'd0);
    send_noise(8);
    wait_idle();
    write_cap(16'hffff);
    run_lines(20);

    // Lowering the limit mid-line lets that line finish, then input is dropped.
    make_line(-1);
    split = $urandom_range(1, line_text.size() - 1);
    send_span(0, split - 1);
    wait_idle();
    write_cap(16'd0);
    send_span(split, line_text.size() - 1);
    send_noise(6);

    // Three more lines are parsed, the rest are dropped until the limit is raised.
    wait_idle();
    write_cap(lines_done + 16'd3);
    repeat (4) begin
      make_line(-1);
      send_span(0, line_text.size() - 1);
    end
    wait_idle();
    write_cap(16'hffff);

    send_gap_pct = 50;
    pop_gap_pct = 35;
    run_lines(60);

    // Back to back, starting with a name longer than the capture.
    send_gap_pct = 0;
    pop_gap_pct = 0;
    make_line(NAME_LIMIT + 20);
    send_span(0, line_text.size() - 1);
    run_lines(20);

    // One fault halts the block for good, so the run ends with one of them.
    fault_pick = 2'($urandom_range(2));
    case (fault_pick)
      mmlp_pkg::ERR_SYNTAX: begin
        if ($urandom_range(1)) begin
          send_item("1", 1'b0);
          send_item("g", 1'b0);
        end else begin
          send_item("1", 1'b0);
          send_item(mmlp_pkg::CHAR_DASH, 1'b0);
          send_item("2", 1'b0);
          send_item(mmlp_pkg::CHAR_NEWLINE, 1'($urandom_range(1)));
        end
      end
      mmlp_pkg::ERR_HEX_FIELD: begin
        case ($urandom_range(2))
          0: begin
            send_item(mmlp_pkg::CHAR_DASH, 1'b0);
            send_item("5", 1'b0);
          end
          1: begin
            send_item("1", 1'b0);
            send_item(mmlp_pkg::CHAR_DASH, 1'b0);
          end
          default: begin
            repeat (mmlp_pkg::HEX_DIGITS_SAT) send_item("f", 1'b0);
            send_item(mmlp_pkg::CHAR_DASH, 1'b0);
            send_item("1", 1'b0);
          end
        endcase
        send_item(mmlp_pkg::CHAR_SPACE, 1'b0);
      end
      default: send_item(text_byte(1'b1), 1'b1);
    endcase
    send_noise(4);

    wait_idle();
    if (mismatches == 0 && results_due.size() == 0) begin
      $display("memory_map_line_parser_tb: done, clean");
    end else begin
      $display("memory_map_line_parser_tb: done, errors");
    end
    $finish;
  end

endmodule
